### hdl/gtht_pkg.sv
// Shared types, codes and constants for the generation-tagged handle table.
package gtht_pkg;

  localparam int HANDLE_SLOTS_DEF = 1024;
  localparam int TABLE_ROWS_DEF   = 64;
  localparam int HANDLE_W         = 10;
  localparam int GEN_W            = 64;
  localparam int CAP_W            = 7;
  localparam int RESULT_LIMIT     = 64;
  localparam int MARK_W           = 4;

  // operation codes
  localparam logic [2:0] OP_OPEN   = 3'd0;
  localparam logic [2:0] OP_ATTACH = 3'd1;
  localparam logic [2:0] OP_DETACH = 3'd2;
  localparam logic [2:0] OP_CLOSE  = 3'd3;
  localparam logic [2:0] OP_CHECK  = 3'd4;
  localparam logic [2:0] OP_COMPL  = 3'd5;
  localparam logic [2:0] OP_SNAP   = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_INVAL  = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;

  localparam logic [1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_WRITE   = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  // row read address select
  localparam logic [1:0] RSEL_MAP  = 2'd0;
  localparam logic [1:0] RSEL_TAIL = 2'd1;
  localparam logic [1:0] RSEL_SCAN = 2'd2;

  typedef struct packed {
    logic [2:0]          operation;
    logic [HANDLE_W-1:0] handle;
    logic [1:0]          kind;
    logic [GEN_W-1:0]    check_generation;
    logic                snap_interest;
    logic [CAP_W-1:0]    max_rows;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                answer;
    logic                row_valid;
    logic [HANDLE_W-1:0] row_handle;
    logic [GEN_W-1:0]    row_generation;
    logic                row_accept;
    logic                row_read;
    logic                row_write;
    logic                last;
  } out_word_t;

  // marks: bit0 accept, bit1 read, bit2 write, bit3 open
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [GEN_W-1:0]    gen;
    logic [MARK_W-1:0]   marks;
  } row_t;

  typedef struct packed {
    logic       clear;
    logic       latch;
    logic       map_rd;
    logic       row_rd;
    logic [1:0] row_sel;
    logic       eval;
    logic       move;
    logic       scan_skip;
    logic       scan_take;
    logic       scan_fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       clear_last;
    logic       need_move;
    logic       out_free;
    logic       scan_more;
    logic       scan_hit;
    logic       pend_valid;
  } dp_stat_t;

endpackage

### hdl/generation_tagged_handle_table.sv
// Generation-tagged handle table: one word in, one result word out per operation
// (snapshot gives one per reported row). The block works on one word at a time,
// paced by the registered-read handle map and row store: lookups, checks, open and
// attach read the map entry, then the row, then write the result word; detach and
// close do the same, then read the tail row and move it into the hole when needed;
// snapshot reads the rows in turn, up to the row count and the capped max_rows. A
// full result register holds off only the step that needs to write it. After reset
// the block clears all HANDLE_SLOTS entries (1024 by default) of the handle map with
// in_ready low; from then on a map entry counts only when it points below the row
// count at a row that carries the same handle.
module generation_tagged_handle_table #(
  parameter int HANDLE_SLOTS = gtht_pkg::HANDLE_SLOTS_DEF,
  parameter int TABLE_ROWS   = gtht_pkg::TABLE_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gtht_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gtht_pkg::out_word_t  out_data
);
  import gtht_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  gtht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gtht_dp #(
    .HANDLE_SLOTS (HANDLE_SLOTS),
    .TABLE_ROWS   (TABLE_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### hdl/gtht_ram.sv
// Generic simple dual-port RAM with registered read.
module gtht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/gtht_ctrl.sv
// Sequencer for the handle table: steps each operation through the datapath.
module gtht_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gtht_pkg::dp_stat_t    stat,
  output gtht_pkg::ctrl_cmd_t   cmd
);
  import gtht_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MAP      = 4'd1;
  localparam logic [3:0] S_ROWRD    = 4'd2;
  localparam logic [3:0] S_EVAL     = 4'd3;
  localparam logic [3:0] S_TAIL     = 4'd4;
  localparam logic [3:0] S_MOVE     = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CK  = 4'd7;
  localparam logic [3:0] S_SCAN_FIN = 4'd8;
  localparam logic [3:0] S_CLEAR    = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.row_sel = RSEL_MAP;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map_rd = 1'b1;
        if (stat.op == OP_SNAP) begin
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_ROWRD;
        end
      end
      S_ROWRD: begin
        cmd.row_rd  = 1'b1;
        cmd.row_sel = RSEL_MAP;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        if (stat.out_free) begin
          cmd.eval  = 1'b1;
          state_nxt = stat.need_move ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        cmd.row_rd  = 1'b1;
        cmd.row_sel = RSEL_TAIL;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        if (stat.scan_more) begin
          cmd.row_rd  = 1'b1;
          cmd.row_sel = RSEL_SCAN;
          state_nxt   = S_SCAN_CK;
        end else begin
          state_nxt = S_SCAN_FIN;
        end
      end
      S_SCAN_CK: begin
        if (!stat.scan_hit) begin
          cmd.scan_skip = 1'b1;
          state_nxt     = S_SCAN_RD;
        end else if (!stat.pend_valid || stat.out_free) begin
          cmd.scan_take = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_SCAN_FIN: begin
        if (!stat.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.scan_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/gtht_dp.sv
// Datapath: handle map, row store, counters, snapshot scan and result register.
module gtht_dp #(
  parameter int HANDLE_SLOTS = gtht_pkg::HANDLE_SLOTS_DEF,
  parameter int TABLE_ROWS   = gtht_pkg::TABLE_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gtht_pkg::in_word_t    in_data,
  input  gtht_pkg::ctrl_cmd_t   cmd,
  output gtht_pkg::dp_stat_t    stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output gtht_pkg::out_word_t   out_data
);
  import gtht_pkg::*;

  localparam int IW = $clog2(TABLE_ROWS);
  localparam int CW = $clog2(TABLE_ROWS + 1);
  localparam int MW = $clog2(HANDLE_SLOTS);
  localparam int RW = $bits(row_t);

  in_word_t          item_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [GEN_W-1:0]  gen_r, gen_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  row_t              pend_r;
  logic [CW-1:0]     scan_i_r, scan_i_nxt;
  logic [CAP_W-1:0]  scan_n_r, scan_n_nxt;
  logic [MW-1:0]     clr_addr_r, clr_addr_nxt;

  logic              map_we;
  logic [MW-1:0]     map_waddr;
  logic [IW-1:0]     map_wdata;
  logic [IW-1:0]     map_idx;
  logic              row_we;
  logic [IW-1:0]     row_waddr;
  logic [RW-1:0]     row_wdata;
  logic [IW-1:0]     row_raddr;
  logic [RW-1:0]     row_rdata;
  row_t              row_q;

  logic              hvalid, found, kind_ok, full, gen_max;
  logic [2:0]        bitm;
  logic [CW-1:0]     tail;
  logic [CAP_W-1:0]  cap;
  logic [MARK_W-1:0] base_marks, new_marks, cut_marks;
  logic [GEN_W-1:0]  base_gen;
  out_word_t         res, pend_word;
  logic              ev_row_we, ev_create, ev_remove;
  logic [IW-1:0]     ev_row_addr;
  row_t              ev_row;
  logic              out_load;

  gtht_ram #(.WIDTH(IW), .DEPTH(HANDLE_SLOTS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (cmd.map_rd),
    .raddr (MW'(item_r.handle)),
    .rdata (map_idx)
  );

  gtht_ram #(.WIDTH(RW), .DEPTH(TABLE_ROWS)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (cmd.row_rd),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  assign row_q = row_t'(row_rdata);

  // decode the held word
  always_comb begin
    case (item_r.kind)
      KIND_ACCEPT: bitm = 3'b001;
      KIND_READ:   bitm = 3'b010;
      KIND_WRITE:  bitm = 3'b100;
      default:     bitm = 3'b000;
    endcase
  end

  assign kind_ok = (item_r.kind != KIND_INVALID);
  assign hvalid  = ({22'd0, item_r.handle} < 32'(HANDLE_SLOTS));
  assign found   = hvalid && (CW'(map_idx) < count_r) && (row_q.handle == item_r.handle);
  assign full    = (count_r == CW'(TABLE_ROWS));
  assign gen_max = &gen_r;
  assign tail    = count_r - CW'(1);
  assign cap     = (item_r.max_rows > CAP_W'(RESULT_LIMIT)) ? CAP_W'(RESULT_LIMIT)
                                                            : item_r.max_rows;

  // select the row read address
  always_comb begin
    case (cmd.row_sel)
      RSEL_TAIL: row_raddr = count_r[IW-1:0];
      RSEL_SCAN: row_raddr = scan_i_r[IW-1:0];
      default:   row_raddr = map_idx;
    endcase
  end

  // work out the result and table update of a single-result operation
  always_comb begin
    res         = '0;
    res.last    = 1'b1;
    ev_row_we   = 1'b0;
    ev_create   = 1'b0;
    ev_remove   = 1'b0;
    ev_row_addr = map_idx;
    ev_row      = row_q;
    base_marks  = found ? row_q.marks : '0;
    base_gen    = found ? row_q.gen : gen_r + GEN_W'(1);
    new_marks   = base_marks;
    cut_marks   = row_q.marks & ~{1'b0, bitm};
    unique case (item_r.operation) inside
      OP_OPEN, OP_ATTACH: begin
        if (item_r.operation == OP_OPEN) begin
          res.row_handle = item_r.handle;
        end
        if (!hvalid) begin
          res.status = ST_INVAL;
        end else if (!found && (full || gen_max)) begin
          res.status = ST_NOROOM;
        end else begin
          if (item_r.operation == OP_OPEN) begin
            new_marks = base_marks | 4'b1000;
          end else if (kind_ok) begin
            new_marks = base_marks | {1'b0, bitm};
          end
          ev_row_we   = 1'b1;
          ev_create   = !found;
          ev_row_addr = found ? map_idx : count_r[IW-1:0];
          ev_row      = '{handle: item_r.handle, gen: base_gen, marks: new_marks};
          if (item_r.operation == OP_OPEN) begin
            res.row_valid      = 1'b1;
            res.row_generation = base_gen;
            res.row_accept     = new_marks[0];
            res.row_read       = new_marks[1];
            res.row_write      = new_marks[2];
          end else if (!kind_ok) begin
            res.status = ST_INVAL;
          end
        end
      end
      OP_DETACH: begin
        if (!kind_ok) begin
          res.status = ST_INVAL;
        end else if (found) begin
          if (cut_marks == '0) begin
            ev_remove = 1'b1;
          end else begin
            ev_row_we    = 1'b1;
            ev_row.marks = cut_marks;
          end
        end
      end
      OP_CLOSE: begin
        res.row_handle = item_r.handle;
        if (found) begin
          res.row_valid      = 1'b1;
          res.row_generation = row_q.gen;
          res.row_accept     = row_q.marks[0];
          res.row_read       = row_q.marks[1];
          res.row_write      = row_q.marks[2];
          ev_remove          = 1'b1;
        end
      end
      OP_CHECK: begin
        res.answer = found && row_q.marks[3] && (row_q.gen == item_r.check_generation);
      end
      OP_COMPL: begin
        res.answer = kind_ok && item_r.snap_interest && found &&
                     (row_q.gen == item_r.check_generation) &&
                     (|(row_q.marks[2:0] & bitm));
      end
      default: begin
        res.status = ST_INVAL;
      end
    endcase
  end

  // steer memory writes: map clearing, evaluation or tail move
  always_comb begin
    map_we    = 1'b0;
    map_waddr = MW'(item_r.handle);
    map_wdata = count_r[IW-1:0];
    row_we    = 1'b0;
    row_waddr = ev_row_addr;
    row_wdata = ev_row;
    if (cmd.clear) begin
      map_we    = 1'b1;
      map_waddr = clr_addr_r;
      map_wdata = '0;
    end else if (cmd.eval) begin
      map_we = ev_create;
      row_we = ev_row_we;
    end else if (cmd.move) begin
      map_we    = 1'b1;
      map_waddr = MW'(row_q.handle);
      map_wdata = map_idx;
      row_we    = 1'b1;
      row_waddr = map_idx;
      row_wdata = row_rdata;
    end
  end

  // format the pending snapshot row
  always_comb begin
    pend_word                = '0;
    pend_word.row_valid      = 1'b1;
    pend_word.row_handle     = pend_r.handle;
    pend_word.row_generation = pend_r.gen;
    pend_word.row_accept     = pend_r.marks[0];
    pend_word.row_read       = pend_r.marks[1];
    pend_word.row_write      = pend_r.marks[2];
    pend_word.last           = cmd.scan_fin;
  end

  // counters, scan and result register next values
  always_comb begin
    count_nxt      = count_r;
    gen_nxt        = gen_r;
    scan_i_nxt     = scan_i_r;
    scan_n_nxt     = scan_n_r;
    pend_valid_nxt = pend_valid_r;
    clr_addr_nxt   = clr_addr_r;
    out_load       = 1'b0;
    out_nxt        = res;
    if (cmd.clear) begin
      clr_addr_nxt = clr_addr_r + MW'(1);
    end
    if (cmd.latch) begin
      scan_i_nxt     = '0;
      scan_n_nxt     = '0;
      pend_valid_nxt = 1'b0;
    end
    if (cmd.eval) begin
      out_load = 1'b1;
      if (ev_create) begin
        count_nxt = count_r + CW'(1);
        gen_nxt   = gen_r + GEN_W'(1);
      end else if (ev_remove) begin
        count_nxt = tail;
      end
    end
    if (cmd.scan_skip) begin
      scan_i_nxt = scan_i_r + CW'(1);
    end
    if (cmd.scan_take) begin
      scan_i_nxt     = scan_i_r + CW'(1);
      scan_n_nxt     = scan_n_r + CAP_W'(1);
      pend_valid_nxt = 1'b1;
      out_load       = pend_valid_r;
      out_nxt        = pend_word;
    end
    if (cmd.scan_fin) begin
      pend_valid_nxt = 1'b0;
      out_load       = 1'b1;
      out_nxt        = pend_word;
    end
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      gen_r        <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      scan_i_r     <= '0;
      scan_n_r     <= '0;
      clr_addr_r   <= '0;
    end else begin
      count_r      <= count_nxt;
      gen_r        <= gen_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      scan_i_r     <= scan_i_nxt;
      scan_n_r     <= scan_n_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (cmd.scan_take) begin
      pend_r <= row_q;
    end
  end

  assign stat.op         = item_r.operation;
  assign stat.clear_last = (clr_addr_r == MW'(HANDLE_SLOTS - 1));
  assign stat.need_move  = ev_remove && (CW'(map_idx) < tail);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.scan_more  = (scan_i_r < count_r) && (scan_n_r < cap);
  assign stat.scan_hit   = |row_q.marks[2:0];
  assign stat.pend_valid = pend_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ROWS))
    else $error("row count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)))
    else $error("row count moved by more than one");

  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (gen_r != $past(gen_r)) |-> (gen_r == $past(gen_r) + GEN_W'(1)))
    else $error("generation counter did not advance by one");

  a_gen_covers_rows: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r >= GEN_W'(count_r))
    else $error("more rows than generations issued");

endmodule
